/* sv/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define OFT_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define OFT_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define OFT_ASSERT_IMP(name, clk, rst, ante, cons)

`define OFT_ASSERT_NXT(name, clk, rst, ante, cons)

`endif

`endif

/* sv/oft_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package oft_pkg;

   localparam int PIX_W       = 8;
   localparam int GREY_LEVELS = 256;
   localparam int BIN_W       = $clog2(GREY_LEVELS);
   localparam int MAX_PIXELS  = 32768;
   localparam int CNT_W       = 16;
   localparam int SUM_W       = PIX_W + CNT_W;
   localparam int PROD_W      = CNT_W + SUM_W;
   localparam int DEN_W       = 2 * CNT_W;
   localparam int NUM_W       = 2 * PROD_W;
   localparam int CMP_W       = NUM_W + DEN_W;

   localparam int MUL_X_W     = NUM_W;
   localparam int MUL_Y_W     = PROD_W;
   localparam int MUL_DIGIT   = 8;
   localparam int MUL_STEPS   = MUL_Y_W / MUL_DIGIT;
   localparam int MUL_CNT_W   = $clog2(MUL_STEPS);
   localparam int MUL_P_W     = MUL_X_W + MUL_Y_W;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_COUNT,
      ST_READ,
      ST_LOAD,
      ST_MUL_GO,
      ST_MUL_WAIT,
      ST_CHECK,
      ST_CMP,
      ST_NEXT,
      ST_RESULT
   } state_type;

   typedef enum logic [2:0] {
      OP_TS,
      OP_LEFT,
      OP_RIGHT,
      OP_DEN,
      OP_SQ,
      OP_LHS,
      OP_RHS
   } op_type;

endpackage

`default_nettype wire

/* sv/oft_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface oft_req_if;
   logic                     valid;
   logic                     ready;
   logic [oft_pkg::PIX_W-1:0] pixel;
   logic                     last_pixel;

   modport source (output valid, output pixel, output last_pixel, input ready);
   modport sink   (input valid, input pixel, input last_pixel, output ready);
endinterface

interface oft_rsp_if;
   logic                     valid;
   logic                     ready;
   logic [oft_pkg::PIX_W-1:0] threshold;
   logic                     truncated;

   modport source (output valid, output threshold, output truncated, input ready);
   modport sink   (input valid, input threshold, input truncated, output ready);
endinterface

`default_nettype wire

/* sv/otsu_frame_threshold.sv */
// Otsu threshold over one frame of 8-bit grey pixels.
//
// req_ch carries pixel and last_pixel; rsp_ch carries threshold and truncated.
// Both are valid/ready channels; a request moves when valid and ready are high.
// Each pixel is a histogram read, then a write back; ready is high
// only between pixels. Pixels past 32768 in a frame are dropped and flagged.
// The request with last_pixel set starts the search over all 256 bins, which
// reuses one 80x40 multiplier. A bin where a class is empty needs only the
// t*count product, any other bin six more products; the top bin always has
// an empty class.
// The search clears each bin as it reads it, so the next frame starts clean.
// The response holds while rsp_ch.ready is low; no request is taken meanwhile.
// One response per frame, none for other pixels.
// After reset the histogram is cleared bin by bin with ready low.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module otsu_frame_threshold (
   input  wire logic  clock,
   input  wire logic  reset,
   oft_req_if.sink    req_ch,
   oft_rsp_if.source  rsp_ch
);

   localparam int BIN_W  = oft_pkg::BIN_W;
   localparam int CNT_W  = oft_pkg::CNT_W;
   localparam int SUM_W  = oft_pkg::SUM_W;
   localparam int PROD_W = oft_pkg::PROD_W;
   localparam int DEN_W  = oft_pkg::DEN_W;
   localparam int NUM_W  = oft_pkg::NUM_W;
   localparam int CMP_W  = oft_pkg::CMP_W;
   localparam int PIX_W  = oft_pkg::PIX_W;

   oft_pkg::state_type state_ff, state_in;
   oft_pkg::op_type    op_ff, op_in;

   logic [BIN_W-1:0]  t_ff, t_in;
   logic [BIN_W-1:0]  pix_ff, pix_in;
   logic              last_ff, last_in;
   logic              cnt_en_ff, cnt_en_in;
   logic [CNT_W-1:0]  total_ff, total_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic              ovf_ff, ovf_in;
   logic [CNT_W-1:0]  c0_ff, c0_in;
   logic [CNT_W-1:0]  c1_ff, c1_in;
   logic [SUM_W-1:0]  s0_ff, s0_in;
   logic [SUM_W-1:0]  s1_ff, s1_in;
   logic [PROD_W-1:0] left_ff, left_in;
   logic [PROD_W-1:0] right_ff, right_in;
   logic [PROD_W-1:0] diff_ff, diff_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [CMP_W-1:0]  lhs_ff, lhs_in;
   logic [NUM_W-1:0]  best_num_ff, best_num_in;
   logic [DEN_W-1:0]  best_den_ff, best_den_in;
   logic [BIN_W-1:0]  best_t_ff, best_t_in;

   logic [CNT_W-1:0]  hist_mem [oft_pkg::GREY_LEVELS];
   logic [CNT_W-1:0]  hist_rd_ff;
   logic              mem_we;
   logic              mem_re;
   logic [BIN_W-1:0]  mem_waddr;
   logic [CNT_W-1:0]  mem_wdata;
   logic [BIN_W-1:0]  mem_raddr;

   logic                              mul_start;
   logic                              mul_busy;
   logic                              mul_done;
   logic [oft_pkg::MUL_X_W-1:0]       mul_x;
   logic [oft_pkg::MUL_Y_W-1:0]       mul_y;
   logic [oft_pkg::MUL_P_W-1:0]       mul_product;

   logic [BIN_W-1:0]  sat_pix;
   logic              t_last;
   logic              class_empty;
   logic              new_best;

   always_comb begin
      if ({1'b0, req_ch.pixel} >= (PIX_W + 1)'(oft_pkg::GREY_LEVELS)) begin
         sat_pix = BIN_W'(oft_pkg::GREY_LEVELS - 1);
      end else begin
         sat_pix = req_ch.pixel[BIN_W-1:0];
      end
      t_last      = (t_ff == BIN_W'(oft_pkg::GREY_LEVELS - 1));
      class_empty = (c0_ff == '0) || (c0_ff == total_ff);
      new_best    = (lhs_ff > mul_product[CMP_W-1:0]);
   end

   oft_mul_unit u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_x    (mul_x),
      .op_y    (mul_y),
      .busy    (mul_busy),
      .done    (mul_done),
      .product (mul_product)
   );

   always_comb begin
      mul_x = '0;
      mul_y = '0;
      case (op_ff)
         oft_pkg::OP_TS: begin
            mul_x = oft_pkg::MUL_X_W'(t_ff);
            mul_y = oft_pkg::MUL_Y_W'(hist_rd_ff);
         end
         oft_pkg::OP_LEFT: begin
            mul_x = oft_pkg::MUL_X_W'(s1_ff);
            mul_y = oft_pkg::MUL_Y_W'(c0_ff);
         end
         oft_pkg::OP_RIGHT: begin
            mul_x = oft_pkg::MUL_X_W'(s0_ff);
            mul_y = oft_pkg::MUL_Y_W'(c1_ff);
         end
         oft_pkg::OP_DEN: begin
            mul_x = oft_pkg::MUL_X_W'(c0_ff);
            mul_y = oft_pkg::MUL_Y_W'(c1_ff);
         end
         oft_pkg::OP_SQ: begin
            mul_x = oft_pkg::MUL_X_W'(diff_ff);
            mul_y = oft_pkg::MUL_Y_W'(diff_ff);
         end
         oft_pkg::OP_LHS: begin
            mul_x = oft_pkg::MUL_X_W'(num_ff);
            mul_y = oft_pkg::MUL_Y_W'(best_den_ff);
         end
         oft_pkg::OP_RHS: begin
            mul_x = oft_pkg::MUL_X_W'(best_num_ff);
            mul_y = oft_pkg::MUL_Y_W'(den_ff);
         end
         default: begin
            mul_x = '0;
            mul_y = '0;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         oft_pkg::ST_CLEAR: begin
            if (t_last) state_in = oft_pkg::ST_IDLE;
         end
         oft_pkg::ST_IDLE: begin
            if (req_ch.valid) state_in = oft_pkg::ST_COUNT;
         end
         oft_pkg::ST_COUNT: begin
            state_in = last_ff ? oft_pkg::ST_READ : oft_pkg::ST_IDLE;
         end
         oft_pkg::ST_READ:   state_in = oft_pkg::ST_LOAD;
         oft_pkg::ST_LOAD:   state_in = oft_pkg::ST_MUL_GO;
         oft_pkg::ST_MUL_GO: state_in = oft_pkg::ST_MUL_WAIT;
         oft_pkg::ST_MUL_WAIT: begin
            if (mul_done) begin
               case (op_ff)
                  oft_pkg::OP_TS:  state_in = oft_pkg::ST_CHECK;
                  oft_pkg::OP_RHS: state_in = oft_pkg::ST_CMP;
                  default:         state_in = oft_pkg::ST_MUL_GO;
               endcase
            end
         end
         oft_pkg::ST_CHECK: begin
            state_in = class_empty ? oft_pkg::ST_NEXT : oft_pkg::ST_MUL_GO;
         end
         oft_pkg::ST_CMP:  state_in = oft_pkg::ST_NEXT;
         oft_pkg::ST_NEXT: begin
            state_in = t_last ? oft_pkg::ST_RESULT : oft_pkg::ST_READ;
         end
         oft_pkg::ST_RESULT: begin
            if (rsp_ch.ready) state_in = oft_pkg::ST_IDLE;
         end
         default: state_in = oft_pkg::ST_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      req_ch.ready     = (state_ff == oft_pkg::ST_IDLE);
      rsp_ch.valid     = (state_ff == oft_pkg::ST_RESULT);
      rsp_ch.threshold = PIX_W'(best_t_ff);
      rsp_ch.truncated = ovf_ff;
      mul_start        = (state_ff == oft_pkg::ST_MUL_GO);
      mem_raddr        = (state_ff == oft_pkg::ST_IDLE) ? sat_pix : t_ff;
      // bin count stays put until the t*count product has started
      mem_re           = (state_ff == oft_pkg::ST_IDLE) || (state_ff == oft_pkg::ST_READ);
      mem_we           = 1'b0;
      mem_waddr        = t_ff;
      mem_wdata        = '0;
      case (state_ff)
         oft_pkg::ST_CLEAR: mem_we = 1'b1;
         oft_pkg::ST_READ:  mem_we = 1'b1;
         oft_pkg::ST_COUNT: begin
            mem_we    = cnt_en_ff;
            mem_waddr = pix_ff;
            mem_wdata = CNT_W'(hist_rd_ff + 1'b1);
         end
         default: mem_we = 1'b0;
      endcase
   end

   // datapath
   always_comb begin
      op_in       = op_ff;
      t_in        = t_ff;
      pix_in      = pix_ff;
      last_in     = last_ff;
      cnt_en_in   = cnt_en_ff;
      total_in    = total_ff;
      sum_in      = sum_ff;
      ovf_in      = ovf_ff;
      c0_in       = c0_ff;
      c1_in       = c1_ff;
      s0_in       = s0_ff;
      s1_in       = s1_ff;
      left_in     = left_ff;
      right_in    = right_ff;
      diff_in     = diff_ff;
      den_in      = den_ff;
      num_in      = num_ff;
      lhs_in      = lhs_ff;
      best_num_in = best_num_ff;
      best_den_in = best_den_ff;
      best_t_in   = best_t_ff;
      case (state_ff)
         oft_pkg::ST_CLEAR: begin
            t_in = t_last ? '0 : t_ff + 1'b1;
         end
         oft_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               pix_in    = sat_pix;
               last_in   = req_ch.last_pixel;
               cnt_en_in = (total_ff < CNT_W'(oft_pkg::MAX_PIXELS));
               if (total_ff < CNT_W'(oft_pkg::MAX_PIXELS)) begin
                  total_in = total_ff + 1'b1;
                  sum_in   = sum_ff + SUM_W'(sat_pix);
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end
         oft_pkg::ST_COUNT: begin
            if (last_ff) begin
               t_in        = '0;
               c0_in       = '0;
               s0_in       = '0;
               best_num_in = '0;
               best_den_in = DEN_W'(1);
               best_t_in   = '0;
            end
         end
         oft_pkg::ST_LOAD: begin
            c0_in = c0_ff + hist_rd_ff;
            op_in = oft_pkg::OP_TS;
         end
         oft_pkg::ST_MUL_WAIT: begin
            if (mul_done) begin
               case (op_ff)
                  oft_pkg::OP_TS: s0_in = s0_ff + mul_product[SUM_W-1:0];
                  oft_pkg::OP_LEFT: begin
                     left_in = mul_product[PROD_W-1:0];
                     op_in   = oft_pkg::OP_RIGHT;
                  end
                  oft_pkg::OP_RIGHT: begin
                     right_in = mul_product[PROD_W-1:0];
                     op_in    = oft_pkg::OP_DEN;
                  end
                  oft_pkg::OP_DEN: begin
                     den_in  = mul_product[DEN_W-1:0];
                     diff_in = (left_ff >= right_ff) ? left_ff - right_ff
                                                     : right_ff - left_ff;
                     op_in   = oft_pkg::OP_SQ;
                  end
                  oft_pkg::OP_SQ: begin
                     num_in = mul_product[NUM_W-1:0];
                     op_in  = oft_pkg::OP_LHS;
                  end
                  oft_pkg::OP_LHS: begin
                     lhs_in = mul_product[CMP_W-1:0];
                     op_in  = oft_pkg::OP_RHS;
                  end
                  default: op_in = op_ff;
               endcase
            end
         end
         oft_pkg::ST_CHECK: begin
            c1_in = total_ff - c0_ff;
            s1_in = sum_ff - s0_ff;
            op_in = oft_pkg::OP_LEFT;
         end
         oft_pkg::ST_CMP: begin
            if (new_best) begin
               best_num_in = num_ff;
               best_den_in = den_ff;
               best_t_in   = t_ff;
            end
         end
         oft_pkg::ST_NEXT: begin
            if (!t_last) t_in = t_ff + 1'b1;
         end
         oft_pkg::ST_RESULT: begin
            if (rsp_ch.ready) begin
               total_in = '0;
               sum_in   = '0;
               ovf_in   = 1'b0;
            end
         end
         default: t_in = t_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= oft_pkg::ST_CLEAR;
         t_ff     <= '0;
         total_ff <= '0;
         sum_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         t_ff     <= t_in;
         total_ff <= total_in;
         sum_ff   <= sum_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      pix_ff      <= pix_in;
      last_ff     <= last_in;
      cnt_en_ff   <= cnt_en_in;
      c0_ff       <= c0_in;
      c1_ff       <= c1_in;
      s0_ff       <= s0_in;
      s1_ff       <= s1_in;
      left_ff     <= left_in;
      right_ff    <= right_in;
      diff_ff     <= diff_in;
      den_ff      <= den_in;
      num_ff      <= num_in;
      lhs_ff      <= lhs_in;
      best_num_ff <= best_num_in;
      best_den_ff <= best_den_in;
      best_t_ff   <= best_t_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) hist_mem[mem_waddr] <= mem_wdata;
      if (mem_re) hist_rd_ff <= hist_mem[mem_raddr];
   end

   `OFT_ASSERT_IMP(a_no_req_during_rsp, clock, reset, rsp_ch.valid, !req_ch.ready)
   `OFT_ASSERT_IMP(a_mul_start_idle, clock, reset, mul_start, !mul_busy)
   `OFT_ASSERT_IMP(a_total_bound, clock, reset, 1'b1, total_ff <= CNT_W'(oft_pkg::MAX_PIXELS))
   `OFT_ASSERT_IMP(a_den_nonzero, clock, reset, state_ff == oft_pkg::ST_CMP, best_den_ff != '0)
   `OFT_ASSERT_NXT(a_frame_reset, clock, reset, rsp_ch.valid && rsp_ch.ready, total_ff == '0)

endmodule

`default_nettype wire

/* sv/oft_mul_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

module oft_mul_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [oft_pkg::MUL_X_W-1:0]   op_x,
   input  wire logic [oft_pkg::MUL_Y_W-1:0]   op_y,
   output logic                               busy,
   output logic                               done,
   output logic [oft_pkg::MUL_P_W-1:0]        product
);

   localparam int PART_W = oft_pkg::MUL_X_W + oft_pkg::MUL_DIGIT;

   logic [oft_pkg::MUL_X_W-1:0]   x_ff, x_in;
   logic [oft_pkg::MUL_Y_W-1:0]   y_ff, y_in;
   logic [oft_pkg::MUL_P_W-1:0]   acc_ff, acc_in;
   logic [oft_pkg::MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [oft_pkg::MUL_DIGIT-1:0] digit;
   logic [PART_W-1:0]             part;

   // MSB-first, one 8-bit digit of y per cycle while busy
   always_comb begin
      digit = y_ff[oft_pkg::MUL_Y_W-1 -: oft_pkg::MUL_DIGIT];
      part  = PART_W'(x_ff) * PART_W'(digit);
   end

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = op_x;
         y_in    = op_y;
         acc_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = (acc_ff << oft_pkg::MUL_DIGIT) + oft_pkg::MUL_P_W'(part);
         y_in   = y_ff << oft_pkg::MUL_DIGIT;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == oft_pkg::MUL_CNT_W'(oft_pkg::MUL_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      acc_ff <= acc_in;
   end

   assign busy    = busy_ff;
   assign done    = done_ff;
   assign product = acc_ff;

endmodule

`default_nettype wire
